// ===== sv/cda_pkg.sv =====
package cda_pkg;

   localparam int YEAR_MAX = 9999;
   localparam int YEAR_END = YEAR_MAX + 1;

   localparam logic [13:0] YEAR_LIMIT = 14'(YEAR_MAX);

   // Serial number of the last supported day, YEAR_MAX-12-31.
   localparam logic signed [23:0] SERIAL_TOP = 24'(365 * YEAR_END
      + (YEAR_END + 3) / 4 - (YEAR_END + 99) / 100
      + (YEAR_END + 399) / 400 - (YEAR_END + 3999) / 4000 - 1);

   localparam logic [13:0] RECIP_100 = 14'd5243;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SER1,
      OP_SER2,
      OP_ADD,
      OP_TRY,
      OP_DATE,
      OP_DIFF,
      OP_RESULT
   } op_type;

   typedef enum logic [1:0] {
      SRC_Y1,
      SRC_Y2,
      SRC_CAND,
      SRC_YR
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type src;
   } cmd_type;

   typedef struct packed {
      logic req;
      logic add_ok;
      logic bit_zero;
      logic out_free;
   } status_type;

   function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] c;
      case (m)
         4'd2:    c = 9'd31;
         4'd3:    c = 9'd59;
         4'd4:    c = 9'd90;
         4'd5:    c = 9'd120;
         4'd6:    c = 9'd151;
         4'd7:    c = 9'd181;
         4'd8:    c = 9'd212;
         4'd9:    c = 9'd243;
         4'd10:   c = 9'd273;
         4'd11:   c = 9'd304;
         4'd12:   c = 9'd334;
         default: c = 9'd0;
      endcase
      return c + {8'd0, (m > 4'd2) && leap};
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      case (m)
         4'd2:    n = leap ? 5'd29 : 5'd28;
         4'd4:    n = 5'd30;
         4'd6:    n = 5'd30;
         4'd9:    n = 5'd30;
         4'd11:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

// ===== sv/cda_dby.sv =====
module cda_dby (
   input  logic        clock,
   input  logic [13:0] year_in,
   output logic [22:0] dby_out,
   output logic        leap_out
);

   logic [13:0] y_ff;
   logic [7:0]  q_ff;
   logic [26:0] prod;
   logic [13:0] hund;
   logic [6:0]  r;
   logic        rnz;
   logic [7:0]  cc;
   logic [12:0] c4;
   logic [12:0] c400;
   logic [2:0]  c4000;
   logic [12:0] leaps;
   logic        c40;
   logic [22:0] dby_in;
   logic        leap_in;
   logic [22:0] dby_ff;
   logic        leap_ff;

   assign prod = {13'd0, year_in} * {13'd0, cda_pkg::RECIP_100};

   always_ff @(posedge clock) begin
      y_ff    <= year_in;
      q_ff    <= prod[26:19];
      dby_ff  <= dby_in;
      leap_ff <= leap_in;
   end

   always_comb begin
      hund  = {6'd0, q_ff} * 14'd100;
      r     = 7'(y_ff - hund);
      rnz   = (r != 7'd0);
      cc    = q_ff + {7'd0, rnz};
      c4    = 13'({5'd0, q_ff} * 13'd25) + {8'd0, 5'(({1'b0, r} + 8'd3) >> 2)};
      c400  = {5'd0, 8'(({1'b0, cc} + 9'd3) >> 2)};
      c4000 = 3'({2'd0, cc > 8'd0} + {2'd0, cc > 8'd40} + {2'd0, cc > 8'd80}
              + {2'd0, cc > 8'd120} + {2'd0, cc > 8'd160});
      leaps = c4 - {5'd0, cc} + c400 - {10'd0, c4000};
      dby_in = 23'({9'd0, y_ff} * 23'd365) + {10'd0, leaps};
      c40   = (q_ff == 8'd0) || (q_ff == 8'd40) || (q_ff == 8'd80)
              || (q_ff == 8'd120) || (q_ff == 8'd160);
      leap_in = (r[1:0] == 2'd0) && (rnz || (q_ff[1:0] == 2'd0)) && !(!rnz && c40);
   end

   assign dby_out  = dby_ff;
   assign leap_out = leap_ff;

endmodule

// ===== sv/cda_datapath.sv =====
module cda_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cda_pkg::cmd_type     cmd,
   output cda_pkg::status_type  status,
   input  logic                 req_type,
   input  logic [13:0]          date_year,
   input  logic [3:0]           date_month,
   input  logic [4:0]           date_day,
   input  logic signed [22:0]   day_offset,
   input  logic [13:0]          other_year,
   input  logic [3:0]           other_month,
   input  logic [4:0]           other_day,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [13:0]          res_year,
   output logic [3:0]           res_month,
   output logic [4:0]           res_day,
   output logic signed [22:0]   day_difference,
   output logic                 first_valid,
   output logic                 second_valid,
   output logic                 range_error
);

   logic               req_ff;
   logic [13:0]        y1_ff, y2_ff;
   logic [3:0]         m1_ff, m2_ff;
   logic [4:0]         d1_ff, d2_ff;
   logic signed [22:0] off_ff;
   logic [22:0]        ser1_ff, ser2_ff;
   logic signed [23:0] sum_ff;
   logic [13:0]        yr_ff;
   logic [3:0]         bit_ff;
   logic               v1_ff, v2_ff, ok_ff, rerr_ff;
   logic [13:0]        ry_ff;
   logic [3:0]         rm_ff;
   logic [4:0]         rd_ff;
   logic [22:0]        diff_ff;
   logic               rsp_valid_ff;

   logic [13:0]        dby_year;
   logic [22:0]        dby;
   logic               leap;
   logic [13:0]        cand;
   logic               cur_valid;
   logic [22:0]        cur_serial;
   logic [13:0]        cur_y;
   logic [3:0]         cur_m;
   logic [4:0]         cur_d;
   logic signed [23:0] sum_in;
   logic               out_of_range;
   logic [8:0]         rem;
   logic [3:0]         mo;
   logic [8:0]         day_rem;
   logic signed [23:0] dd;

   assign cand = yr_ff | (14'd1 << bit_ff);

   always_comb begin
      case (cmd.src)
         cda_pkg::SRC_Y1:   dby_year = y1_ff;
         cda_pkg::SRC_Y2:   dby_year = y2_ff;
         cda_pkg::SRC_CAND: dby_year = cand;
         default:           dby_year = yr_ff;
      endcase
   end

   cda_dby u_dby (
      .clock    (clock),
      .year_in  (dby_year),
      .dby_out  (dby),
      .leap_out (leap)
   );

   always_comb begin
      cur_y = (cmd.op == cda_pkg::OP_SER2) ? y2_ff : y1_ff;
      cur_m = (cmd.op == cda_pkg::OP_SER2) ? m2_ff : m1_ff;
      cur_d = (cmd.op == cda_pkg::OP_SER2) ? d2_ff : d1_ff;
      cur_valid = (cur_y <= cda_pkg::YEAR_LIMIT) && (cur_m >= 4'd1) && (cur_m <= 4'd12)
                  && (cur_d >= 5'd1) && (cur_d <= cda_pkg::month_len(cur_m, leap));
      cur_serial = dby + {14'd0, cda_pkg::cum_days(cur_m, leap)} + {18'd0, cur_d} - 23'd1;
      sum_in = $signed({1'b0, ser1_ff}) + $signed({off_ff[22], off_ff});
      out_of_range = sum_in[23] || (sum_in > cda_pkg::SERIAL_TOP);
      rem = 9'(sum_ff[22:0] - dby);
      mo = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         if (cda_pkg::cum_days(4'(k), leap) <= rem) begin
            mo = 4'(k);
         end
      end
      day_rem = rem - cda_pkg::cum_days(mo, leap) + 9'd1;
      dd = $signed({1'b0, ser2_ff}) - $signed({1'b0, ser1_ff});
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         cda_pkg::OP_LOAD: begin
            req_ff  <= req_type;
            y1_ff   <= date_year;
            m1_ff   <= date_month;
            d1_ff   <= date_day;
            off_ff  <= day_offset;
            y2_ff   <= other_year;
            m2_ff   <= other_month;
            d2_ff   <= other_day;
            v2_ff   <= 1'b0;
            ok_ff   <= 1'b0;
            rerr_ff <= 1'b0;
            ry_ff   <= 14'd0;
            rm_ff   <= 4'd0;
            rd_ff   <= 5'd0;
            diff_ff <= 23'd0;
         end
         cda_pkg::OP_SER1: begin
            v1_ff   <= cur_valid;
            ser1_ff <= cur_serial;
         end
         cda_pkg::OP_SER2: begin
            v2_ff   <= cur_valid;
            ser2_ff <= cur_serial;
         end
         cda_pkg::OP_ADD: begin
            sum_ff  <= sum_in;
            ok_ff   <= v1_ff && !out_of_range;
            rerr_ff <= v1_ff && out_of_range;
            yr_ff   <= 14'd0;
            bit_ff  <= 4'd13;
         end
         cda_pkg::OP_TRY: begin
            if ((cand <= cda_pkg::YEAR_LIMIT) && (dby <= sum_ff[22:0])) begin
               yr_ff <= cand;
            end
            bit_ff <= bit_ff - 4'd1;
         end
         cda_pkg::OP_DATE: begin
            ry_ff <= yr_ff;
            rm_ff <= mo;
            rd_ff <= day_rem[4:0];
         end
         cda_pkg::OP_DIFF: begin
            if (v1_ff && v2_ff) begin
               diff_ff <= dd[22:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == cda_pkg::OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == cda_pkg::OP_RESULT) begin
         res_year       <= ry_ff;
         res_month      <= rm_ff;
         res_day        <= rd_ff;
         day_difference <= diff_ff;
         first_valid    <= v1_ff;
         second_valid   <= v2_ff;
         range_error    <= rerr_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.req      = req_ff;
   assign status.add_ok   = ok_ff;
   assign status.bit_zero = (bit_ff == 4'd0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== sv/cda_control.sv =====
module cda_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cda_pkg::status_type  status,
   output cda_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_S1A, ST_S1W, ST_S1C, ST_S2A, ST_S2W, ST_S2C, ST_DIFF,
      ST_ADD, ST_CHK, ST_TA, ST_TW, ST_TC, ST_DA, ST_DW, ST_DC
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd.op   = cda_pkg::OP_NONE;
      cmd.src  = cda_pkg::SRC_Y1;
      if (fin_ff) begin
         if (status.out_free) begin
            cmd.op = cda_pkg::OP_RESULT;
            fin_in = 1'b0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd.op   = cda_pkg::OP_LOAD;
                  state_in = ST_S1A;
               end
            end
            ST_S1A: state_in = ST_S1W;
            ST_S1W: state_in = ST_S1C;
            ST_S1C: begin
               cmd.op   = cda_pkg::OP_SER1;
               state_in = status.req ? ST_S2A : ST_ADD;
            end
            ST_S2A: begin
               cmd.src  = cda_pkg::SRC_Y2;
               state_in = ST_S2W;
            end
            ST_S2W: begin
               cmd.src  = cda_pkg::SRC_Y2;
               state_in = ST_S2C;
            end
            ST_S2C: begin
               cmd.src  = cda_pkg::SRC_Y2;
               cmd.op   = cda_pkg::OP_SER2;
               state_in = ST_DIFF;
            end
            ST_DIFF: begin
               cmd.op   = cda_pkg::OP_DIFF;
               state_in = ST_IDLE;
               fin_in   = 1'b1;
            end
            ST_ADD: begin
               cmd.op   = cda_pkg::OP_ADD;
               state_in = ST_CHK;
            end
            ST_CHK: begin
               if (status.add_ok) begin
                  state_in = ST_TA;
               end else begin
                  state_in = ST_IDLE;
                  fin_in   = 1'b1;
               end
            end
            ST_TA: begin
               cmd.src  = cda_pkg::SRC_CAND;
               state_in = ST_TW;
            end
            ST_TW: begin
               cmd.src  = cda_pkg::SRC_CAND;
               state_in = ST_TC;
            end
            ST_TC: begin
               cmd.src  = cda_pkg::SRC_CAND;
               cmd.op   = cda_pkg::OP_TRY;
               state_in = status.bit_zero ? ST_DA : ST_TA;
            end
            ST_DA: begin
               cmd.src  = cda_pkg::SRC_YR;
               state_in = ST_DW;
            end
            ST_DW: begin
               cmd.src  = cda_pkg::SRC_YR;
               state_in = ST_DC;
            end
            ST_DC: begin
               cmd.src  = cda_pkg::SRC_YR;
               cmd.op   = cda_pkg::OP_DATE;
               state_in = ST_IDLE;
               fin_in   = 1'b1;
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   assign req_stall = fin_ff || (state_ff != ST_IDLE);

endmodule

// ===== sv/calendar_date_arithmetic.sv =====
// A difference transaction has its result registered after both serial numbers are formed.
// An add transaction runs a 14-step binary year search through the two-stage days-before-year
// unit; an invalid or out-of-range add skips the search.
// One transaction is in work at a time; the next can be accepted in the cycle after the result is
// registered, and the result is registered only once the output is free.
// Synchronous active-high reset returns the controller to idle and drops rsp_valid.
module calendar_date_arithmetic (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [13:0]        date_year,
   input  logic [3:0]         date_month,
   input  logic [4:0]         date_day,
   input  logic signed [22:0] day_offset,
   input  logic [13:0]        other_year,
   input  logic [3:0]         other_month,
   input  logic [4:0]         other_day,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        res_year,
   output logic [3:0]         res_month,
   output logic [4:0]         res_day,
   output logic signed [22:0] day_difference,
   output logic               first_valid,
   output logic               second_valid,
   output logic               range_error
);

   cda_pkg::cmd_type    cmd;
   cda_pkg::status_type status;

   cda_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cda_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .date_year      (date_year),
      .date_month     (date_month),
      .date_day       (date_day),
      .day_offset     (day_offset),
      .other_year     (other_year),
      .other_month    (other_month),
      .other_day      (other_day),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .res_year       (res_year),
      .res_month      (res_month),
      .res_day        (res_day),
      .day_difference (day_difference),
      .first_valid    (first_valid),
      .second_valid   (second_valid),
      .range_error    (range_error)
   );

endmodule

// ===== test/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1430;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_type = 0;
   logic [13:0] date_year = 0;
   logic [3:0] date_month = 0;
   logic [4:0] date_day = 0;
   logic signed [22:0] day_offset = 0;
   logic [13:0] other_year = 0;
   logic [3:0] other_month = 0;
   logic [4:0] other_day = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [13:0] res_year;
   logic [3:0] res_month;
   logic [4:0] res_day;
   logic signed [22:0] day_difference;
   logic first_valid, second_valid, range_error;

   typedef struct packed {
      logic        kind;
      logic [13:0] y1;
      logic [3:0]  m1;
      logic [4:0]  d1;
      logic [22:0] off;
      logic [13:0] y2;
      logic [3:0]  m2;
      logic [4:0]  d2;
   } date_req_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [22:0] diff;
      logic        v1;
      logic        v2;
      logic        rerr;
   } date_rsp_type;

   typedef struct packed {
      date_req_type req;
      logic         fixed;
      date_rsp_type rsp;
   } table_row_type;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_DIFF = 1'b1;

   date_rsp_type expected_dates[$];
   int errors = 0;
   int n_sent = 0, n_recv = 0, n_add = 0, n_diff = 0, n_rerr = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;

   calendar_date_arithmetic dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit is_leap(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)) && (y % 4000 != 0);
   endfunction

   function automatic int days_in_month(int y, int m);
      int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && is_leap(y)) return 29;
      return lens[(m - 1) % 12];
   endfunction

   function automatic longint days_to_year(int y);
      longint yl;
      yl = longint'(y);
      return 365 * yl + (yl + 3) / 4 - ((yl + 99) / 100 - (yl + 399) / 400)
             - (yl + 3999) / 4000;
   endfunction

   function automatic bit date_is_valid(int y, int m, int d);
      if (y > cda_pkg::YEAR_MAX || m < 1 || m > 12 || d < 1) return 0;
      return d <= days_in_month(y, m);
   endfunction

   function automatic longint day_number(int y, int m, int d);
      longint s;
      s = days_to_year(y);
      for (int i = 1; i < m; i++) s += days_in_month(y, i);
      return s + d - 1;
   endfunction

   function automatic date_rsp_type compute_date(date_req_type r);
      date_rsp_type o;
      longint s, top, dd, rem;
      int yr, mo;
      o = '0;
      o.v1 = date_is_valid(int'(r.y1), int'(r.m1), int'(r.d1));
      if (r.kind == KIND_ADD) begin
         if (o.v1) begin
            s = day_number(int'(r.y1), int'(r.m1), int'(r.d1)) + longint'($signed(r.off));
            top = days_to_year(cda_pkg::YEAR_MAX + 1) - 1;
            if (s < 0 || s > top) begin
               o.rerr = 1;
            end else begin
               yr = int'(s / 366);
               while (yr < cda_pkg::YEAR_MAX && days_to_year(yr + 1) <= s) yr++;
               rem = s - days_to_year(yr);
               mo = 1;
               while (mo < 12 && rem >= days_in_month(yr, mo)) begin
                  rem -= days_in_month(yr, mo);
                  mo++;
               end
               o.year = 14'(yr);
               o.month = 4'(mo);
               o.day = 5'(rem + 1);
            end
         end
      end else begin
         o.v2 = date_is_valid(int'(r.y2), int'(r.m2), int'(r.d2));
         if (o.v1 && o.v2) begin
            dd = day_number(int'(r.y2), int'(r.m2), int'(r.d2))
                 - day_number(int'(r.y1), int'(r.m1), int'(r.d1));
            if (dd > 4194303) begin
               dd = 4194303;
               o.rerr = 1;
            end else if (dd < -4194304) begin
               dd = -4194304;
               o.rerr = 1;
            end
            o.diff = dd[22:0];
         end
      end
      return o;
   endfunction

   function automatic date_req_type random_date_req();
      date_req_type r;
      int sel;
      r.kind = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 9);
      r.y1 = 14'((sel < 7) ? $urandom_range(0, cda_pkg::YEAR_MAX) : $urandom);
      r.m1 = 4'((sel < 8) ? $urandom_range(1, 12) : $urandom);
      r.d1 = 5'((sel < 8) ? $urandom_range(1, 28) : $urandom);
      if (sel == 3) r.d1 = 5'($urandom_range(28, 31));
      sel = $urandom_range(0, 9);
      r.y2 = 14'((sel < 7) ? $urandom_range(0, cda_pkg::YEAR_MAX) : $urandom);
      r.m2 = 4'((sel < 8) ? $urandom_range(1, 12) : $urandom);
      r.d2 = 5'((sel < 8) ? $urandom_range(1, 28) : $urandom);
      if (sel == 3) r.d2 = 5'($urandom_range(28, 31));
      case ($urandom_range(0, 3))
         0: r.off = 23'($urandom);
         1: r.off = 23'($urandom_range(0, 800) - 400);
         2: r.off = 23'($urandom_range(0, 80000) - 40000);
         default: r.off = 23'($urandom_range(0, 7300000) - 3650000);
      endcase
      return r;
   endfunction

   function automatic date_req_type mk(logic k, int y1, int m1, int d1, int off,
                                       int y2, int m2, int d2);
      date_req_type r;
      r.kind = k;
      r.y1 = 14'(y1); r.m1 = 4'(m1); r.d1 = 5'(d1); r.off = 23'(off);
      r.y2 = 14'(y2); r.m2 = 4'(m2); r.d2 = 5'(d2);
      return r;
   endfunction

   function automatic table_row_type row(date_req_type r, logic fixed, date_rsp_type o);
      table_row_type t;
      t.req = r;
      t.fixed = fixed;
      t.rsp = o;
      return t;
   endfunction

   task automatic send_date(date_req_type r);
      int gap;
      gap = $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_type <= r.kind;
      date_year <= r.y1;
      date_month <= r.m1;
      date_day <= r.d1;
      day_offset <= r.off;
      other_year <= r.y2;
      other_month <= r.m2;
      other_day <= r.d2;
      do @(posedge clock); while (req_stall);
      n_sent++;
      if (r.kind == KIND_ADD) n_add++; else n_diff++;
   endtask

   task automatic queue_row(table_row_type t);
      date_rsp_type p;
      p = compute_date(t.req);
      if (t.fixed && p != t.rsp) begin
         $error("table row disagrees with predictor: %h vs %h", t.rsp, p);
         errors++;
      end
      expected_dates.push_back(t.fixed ? t.rsp : p);
   endtask

   initial begin
      table_row_type rows[$];
      date_rsp_type z;
      date_req_type r;
      z = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      rows.push_back(row(mk(KIND_ADD, 0, 1, 1, 0, 0, 0, 0), 1,
                         '{14'd0, 4'd1, 5'd1, 23'd0, 1'b1, 1'b0, 1'b0}));
      rows.push_back(row(mk(KIND_ADD, 0, 1, 1, -1, 0, 0, 0), 1,
                         '{14'd0, 4'd0, 5'd0, 23'd0, 1'b1, 1'b0, 1'b1}));
      rows.push_back(row(mk(KIND_ADD, 9999, 12, 31, 0, 0, 0, 0), 1,
                         '{14'd9999, 4'd12, 5'd31, 23'd0, 1'b1, 1'b0, 1'b0}));
      rows.push_back(row(mk(KIND_ADD, 9999, 12, 31, 1, 0, 0, 0), 1,
                         '{14'd0, 4'd0, 5'd0, 23'd0, 1'b1, 1'b0, 1'b1}));
      rows.push_back(row(mk(KIND_ADD, 2000, 1, 0, 5, 0, 0, 0), 1, z));
      rows.push_back(row(mk(KIND_ADD, 2000, 13, 1, 5, 0, 0, 0), 1, z));
      rows.push_back(row(mk(KIND_ADD, 16383, 15, 31, 5, 0, 0, 0), 1, z));
      rows.push_back(row(mk(KIND_ADD, 2001, 2, 29, 5, 0, 0, 0), 1, z));
      rows.push_back(row(mk(KIND_ADD, 2000, 2, 28, 1, 0, 0, 0), 0, z));
      rows.push_back(row(mk(KIND_ADD, 1900, 2, 28, 1, 0, 0, 0), 0, z));
      rows.push_back(row(mk(KIND_ADD, 4000, 2, 28, 1, 0, 0, 0), 0, z));
      rows.push_back(row(mk(KIND_ADD, 5000, 6, 15, 4194303, 0, 0, 0), 0, z));
      rows.push_back(row(mk(KIND_ADD, 5000, 6, 15, -4194304, 0, 0, 0), 0, z));
      rows.push_back(row(mk(KIND_ADD, 0, 1, 1, 3652058, 0, 0, 0), 0, z));
      rows.push_back(row(mk(KIND_DIFF, 0, 1, 1, 0, 0, 1, 1), 1,
                         '{14'd0, 4'd0, 5'd0, 23'd0, 1'b1, 1'b1, 1'b0}));
      rows.push_back(row(mk(KIND_DIFF, 2000, 1, 1, 0, 2000, 0, 1), 1,
                         '{14'd0, 4'd0, 5'd0, 23'd0, 1'b1, 1'b0, 1'b0}));
      rows.push_back(row(mk(KIND_DIFF, 2000, 1, 32 - 32, 0, 2000, 1, 1), 1,
                         '{14'd0, 4'd0, 5'd0, 23'd0, 1'b0, 1'b1, 1'b0}));
      rows.push_back(row(mk(KIND_DIFF, 0, 1, 1, 0, 9999, 12, 31), 0, z));
      rows.push_back(row(mk(KIND_DIFF, 9999, 12, 31, 0, 0, 1, 1), 0, z));
      rows.push_back(row(mk(KIND_DIFF, 4000, 3, 1, 0, 4000, 2, 28), 0, z));
      rows.push_back(row(mk(KIND_DIFF, 16383, 15, 31, 0, 16383, 15, 31), 1, z));
      foreach (rows[i]) begin
         queue_row(rows[i]);
         send_date(rows[i].req);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         r = random_date_req();
         expected_dates.push_back(compute_date(r));
         send_date(r);
      end
      @(negedge clock);
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (!reset);
      wait (n_sent >= 40);
      @(posedge clock);
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      int gap;
      wait (!reset);
      forever begin
         gap = $urandom_range(0, 7);
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1;
         end
         do begin
            @(negedge clock);
            rsp_stall <= hold_rsp;
            @(posedge clock);
         end while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      date_rsp_type a, e;
      if (!reset && rsp_valid && !rsp_stall) begin
         a = '{res_year, res_month, res_day, day_difference, first_valid,
               second_valid, range_error};
         n_recv++;
         if (a.rerr) n_rerr++;
         if (expected_dates.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            e = expected_dates.pop_front();
            if (a.year !== e.year) begin
               $error("res_year expected %0d actual %0d", e.year, a.year); errors++;
            end
            if (a.month !== e.month) begin
               $error("res_month expected %0d actual %0d", e.month, a.month); errors++;
            end
            if (a.day !== e.day) begin
               $error("res_day expected %0d actual %0d", e.day, a.day); errors++;
            end
            if (a.diff !== e.diff) begin
               $error("day_difference expected %0d actual %0d",
                      $signed(e.diff), $signed(a.diff)); errors++;
            end
            if (a.v1 !== e.v1) begin
               $error("first_valid expected %0d actual %0d", e.v1, a.v1); errors++;
            end
            if (a.v2 !== e.v2) begin
               $error("second_valid expected %0d actual %0d", e.v2, a.v2); errors++;
            end
            if (a.rerr !== e.rerr) begin
               $error("range_error expected %0d actual %0d", e.rerr, a.rerr); errors++;
            end
         end
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_dates.size() == 0);
      repeat (100) @(posedge clock);
      if (expected_dates.size() != 0) begin
         $error("%0d results never arrived", expected_dates.size());
         errors++;
      end
      $display("Covered %0d requests (%0d add, %0d difference), %0d results, %0d range errors.",
               n_sent, n_add, n_diff, n_recv, n_rerr);
      if (errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule
